FILE: sv/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SAT_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: implication failed");

// next-cycle implication, off during reset
`define SAT_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: next-cycle implication failed");

// next-cycle implication, checked during reset as well
`define SAT_ASSERT_NXT_ALL(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("%m: next-cycle implication failed");

`endif

FILE: sv/sat_pkg.sv
package sat_pkg;

  localparam int SAT_MAX_SECTIONS = 16;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_V2F   = 2'd1;
  localparam logic [1:0] KIND_F2V   = 2'd2;

  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [31:0] virt_base;
    logic [31:0] virt_size;
    logic [31:0] file_base;
    logic [31:0] file_size;
  } table_wr_t;

endpackage

FILE: sv/sat_table.sv
module sat_table import sat_pkg::*; #(
  parameter int MAX_SECTIONS = SAT_MAX_SECTIONS
) (
  input  logic                    clk,
  input  table_wr_t               wr,
  input  logic [4:0]              count,
  input  logic [1:0]              cmp_kind,
  input  logic [31:0]             cmp_addr,
  output logic [MAX_SECTIONS-1:0] hit,
  input  logic [1:0]              sel_kind,
  input  logic [MAX_SECTIONS-1:0] sel_onehot,
  output logic [31:0]             from_sel,
  output logic [31:0]             to_sel
);

  logic [31:0] vb [MAX_SECTIONS];
  logic [31:0] vs [MAX_SECTIONS];
  logic [31:0] fb [MAX_SECTIONS];
  logic [31:0] fs [MAX_SECTIONS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      if (wr.en && (32'(wr.idx) == 32'(i))) begin
        vb[i] <= wr.virt_base;
        vs[i] <= wr.virt_size;
        fb[i] <= wr.file_base;
        fs[i] <= wr.file_size;
      end
    end
  end

  // one comparator pair per entry
  always_comb begin
    logic [31:0] base;
    logic [31:0] size;
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      base = (cmp_kind == KIND_F2V) ? fb[i] : vb[i];
      size = (cmp_kind == KIND_F2V) ? fs[i] : vs[i];
      hit[i] = (32'(i) < 32'(count)) && (cmp_addr >= base) &&
               ((cmp_addr - base) < size);
    end
  end

  // and-or read of the winning entry
  always_comb begin
    from_sel = '0;
    to_sel   = '0;
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      if (sel_onehot[i]) begin
        from_sel = from_sel | ((sel_kind == KIND_F2V) ? fb[i] : vb[i]);
        to_sel   = to_sel   | ((sel_kind == KIND_F2V) ? vb[i] : fb[i]);
      end
    end
  end

endmodule

FILE: sv/sat_prio.sv
module sat_prio import sat_pkg::*; #(
  parameter int N    = SAT_MAX_SECTIONS,
  parameter int IDXW = 4
) (
  input  logic [N-1:0]    hit,
  output logic [N-1:0]    onehot,
  output logic [IDXW-1:0] idx,
  output logic            any
);

  // lowest set bit
  assign onehot = hit & (~hit + N'(1));
  assign any    = |hit;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | IDXW'(i);
      end
    end
  end

endmodule

FILE: sv/section_address_translate_core.sv
// Section address translator: a table of MAX_SECTIONS entries, loaded by
// write requests, translates virtual addresses to file offsets and back.
// All entries are compared in parallel and the lowest matching entry wins.
// One request can be accepted every cycle while the output is not stalled;
// write requests and kind 3 give no response. The pipeline is input
// register, compare, select and subtract, add and output register. A write
// updates the table as it leaves the compare stage, so it waits there while
// a lookup in the select stage is held by a stalled output. The user must
// write the section count on the cfg port only while no request is in
// flight; the block does not enforce this.
module section_address_translate_core import sat_pkg::*; #(
  parameter int MAX_SECTIONS = SAT_MAX_SECTIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  section_count,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  kind,
  input  logic [3:0]  entry_index,
  input  logic [31:0] virt_base,
  input  logic [31:0] virt_size,
  input  logic [31:0] file_base,
  input  logic [31:0] file_size,
  input  logic [31:0] lookup_address,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] translated,
  output logic        found,
  output logic [3:0]  section_index
);

  localparam int IDXW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  logic [4:0] active_count;

  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [3:0]  s1_idx;
  logic [31:0] s1_vb, s1_vs, s1_fb, s1_fs, s1_addr;

  logic                    s2_valid;
  logic [1:0]              s2_kind;
  logic [31:0]             s2_addr;
  logic [MAX_SECTIONS-1:0] s2_hit;

  logic            s3_valid;
  logic            s3_found;
  logic [IDXW-1:0] s3_idx;
  logic [31:0]     s3_diff;
  logic [31:0]     s3_to;

  logic free2, free3, free4;
  logic s1_lookup;

  table_wr_t               wr;
  logic [MAX_SECTIONS-1:0] hit;
  logic [MAX_SECTIONS-1:0] onehot;
  logic [IDXW-1:0]         win_idx;
  logic                    win_any;
  logic [31:0]             from_sel, to_sel;
  logic [IDXW+3:0]         idx_ext;

  assign free4     = !rsp_valid || rsp_ready;
  assign free3     = !s3_valid || free4;
  assign free2     = !s2_valid || free3;
  assign req_ready = !s1_valid || free2;
  assign cfg_ready = 1'b1;

  assign s1_lookup = (s1_kind == KIND_V2F) || (s1_kind == KIND_F2V);

  always_comb begin
    wr           = '0;
    wr.en        = s1_valid && free2 && (s1_kind == KIND_WRITE) &&
                   (32'(s1_idx) < 32'(MAX_SECTIONS));
    wr.idx       = s1_idx;
    wr.virt_base = s1_vb;
    wr.virt_size = s1_vs;
    wr.file_base = s1_fb;
    wr.file_size = s1_fs;
  end

  sat_table #(.MAX_SECTIONS(MAX_SECTIONS)) u_table (
    .clk       (clk),
    .wr        (wr),
    .count     (active_count),
    .cmp_kind  (s1_kind),
    .cmp_addr  (s1_addr),
    .hit       (hit),
    .sel_kind  (s2_kind),
    .sel_onehot(onehot),
    .from_sel  (from_sel),
    .to_sel    (to_sel)
  );

  sat_prio #(.N(MAX_SECTIONS), .IDXW(IDXW)) u_prio (
    .hit   (s2_hit),
    .onehot(onehot),
    .idx   (win_idx),
    .any   (win_any)
  );

  assign idx_ext = {4'b0, s3_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_count <= section_count;
      end
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (free2) begin
        s2_valid <= s1_valid && s1_lookup;
      end
      if (free3) begin
        s3_valid <= s2_valid;
      end
      if (free4) begin
        rsp_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_kind <= kind;
      s1_idx  <= entry_index;
      s1_vb   <= virt_base;
      s1_vs   <= virt_size;
      s1_fb   <= file_base;
      s1_fs   <= file_size;
      s1_addr <= lookup_address;
    end
    if (free2 && s1_valid) begin
      s2_kind <= s1_kind;
      s2_addr <= s1_addr;
      s2_hit  <= hit;
    end
    if (free3 && s2_valid) begin
      s3_found <= win_any;
      s3_idx   <= win_idx;
      s3_diff  <= s2_addr - from_sel;
      s3_to    <= to_sel;
    end
    if (free4 && s3_valid) begin
      translated    <= s3_found ? (s3_diff + s3_to) : 32'd0;
      found         <= s3_found;
      section_index <= s3_found ? idx_ext[3:0] : 4'd0;
    end
  end

endmodule

FILE: sv/sat_checker.sv
`include "assert_macros.svh"

module sat_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] translated,
  input logic        found,
  input logic [3:0]  section_index
);

  `SAT_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(translated) && $stable(found) && $stable(section_index))
  `SAT_ASSERT_IMP(a_miss_zero, clk, rst, rsp_valid && !found, (translated == 32'd0) && (section_index == 4'd0))
  `SAT_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !rsp_valid)

endmodule

bind section_address_translate_core sat_checker u_sat_checker (.*);

FILE: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PIPE_DRAIN = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry;
    logic [31:0] vbase;
    logic [31:0] vsize;
    logic [31:0] fbase;
    logic [31:0] fsize;
    logic [31:0] addr;
  } section_request_t;

  typedef struct packed {
    logic [31:0] offset;
    logic        hit;
    logic [3:0]  index;
  } translation_t;

  class section_translate_scoreboard;
    logic [SAT_MAX_SECTIONS-1:0][31:0] vbase;
    logic [SAT_MAX_SECTIONS-1:0][31:0] vsize;
    logic [SAT_MAX_SECTIONS-1:0][31:0] fbase;
    logic [SAT_MAX_SECTIONS-1:0][31:0] fsize;
    logic [4:0]   count_reg;
    translation_t pending_translations[$];
    int mismatches;
    int writes;
    int hits;
    int misses;

    function new();
      vbase = '0;
      vsize = '0;
      fbase = '0;
      fsize = '0;
      count_reg = '0;
      mismatches = 0;
      writes = 0;
      hits = 0;
      misses = 0;
    endfunction

    function int active_sections();
      return (count_reg > SAT_MAX_SECTIONS) ? SAT_MAX_SECTIONS : int'(count_reg);
    endfunction

    // first entry holding the address wins, sums wrap at 32 bits
    function translation_t translate_address(logic [1:0] k, logic [31:0] a);
      translation_t t;
      logic [31:0]  from_b;
      logic [31:0]  from_s;
      logic [31:0]  to_b;
      int           n;
      t = '0;
      n = active_sections();
      for (int i = 0; i < n && !t.hit; i++) begin
        from_b = (k == KIND_V2F) ? vbase[i] : fbase[i];
        from_s = (k == KIND_V2F) ? vsize[i] : fsize[i];
        to_b   = (k == KIND_V2F) ? fbase[i] : vbase[i];
        if (a >= from_b && (a - from_b) < from_s) begin
          t.offset = a - from_b + to_b;
          t.hit    = 1'b1;
          t.index  = 4'(i);
        end
      end
      return t;
    endfunction

    function void note_request(section_request_t r);
      translation_t t;
      if (r.kind == KIND_WRITE) begin
        vbase[r.entry] = r.vbase;
        vsize[r.entry] = r.vsize;
        fbase[r.entry] = r.fbase;
        fsize[r.entry] = r.fsize;
        writes++;
      end else if (r.kind == KIND_V2F || r.kind == KIND_F2V) begin
        t = translate_address(r.kind, r.addr);
        if (t.hit) hits++;
        else misses++;
        pending_translations.push_back(t);
      end
    endfunction

    function void check_translation(logic [31:0] offset, logic hit, logic [3:0] index);
      translation_t t;
      if (pending_translations.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual translated %h found %b index %0d",
                 $time, offset, hit, index);
        mismatches++;
        return;
      end
      t = pending_translations.pop_front();
      if (offset !== t.offset) begin
        $display("%0t: translated expected %h actual %h", $time, t.offset, offset);
        mismatches++;
      end
      if (hit !== t.hit) begin
        $display("%0t: found expected %b actual %b", $time, t.hit, hit);
        mismatches++;
      end
      if (index !== t.index) begin
        $display("%0t: section_index expected %0d actual %0d", $time, t.index, index);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  section_count;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  kind;
  logic [3:0]  entry_index;
  logic [31:0] virt_base;
  logic [31:0] virt_size;
  logic [31:0] file_base;
  logic [31:0] file_size;
  logic [31:0] lookup_address;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [31:0] translated;
  logic        found;
  logic [3:0]  section_index;

  section_translate_scoreboard sb;
  bit throttle;
  int cycle_count;

  section_address_translate_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .section_count (section_count),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .kind          (kind),
    .entry_index   (entry_index),
    .virt_base     (virt_base),
    .virt_size     (virt_size),
    .file_base     (file_base),
    .file_size     (file_size),
    .lookup_address(lookup_address),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .translated    (translated),
    .found         (found),
    .section_index (section_index)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  // response side, ready drops at random while throttling
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        sb.check_translation(translated, found, section_index);
      end
      rsp_ready <= !(throttle && $urandom_range(99) < 32);
    end
  end

  function automatic section_request_t write_item(logic [3:0] e, logic [31:0] vb,
                                                  logic [31:0] vs, logic [31:0] fb,
                                                  logic [31:0] fs);
    section_request_t r;
    r.kind  = KIND_WRITE;
    r.entry = e;
    r.vbase = vb;
    r.vsize = vs;
    r.fbase = fb;
    r.fsize = fs;
    r.addr  = $urandom;
    return r;
  endfunction

  function automatic section_request_t lookup_item(logic [1:0] k, logic [31:0] a);
    section_request_t r;
    r.kind  = k;
    r.entry = 4'($urandom_range(15));
    r.vbase = $urandom;
    r.vsize = $urandom;
    r.fbase = $urandom;
    r.fsize = $urandom;
    r.addr  = a;
    return r;
  endfunction

  function automatic logic [31:0] random_base();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return $urandom_range(32'hFFFF);
      2: return 32'hFFFF_FFFF - $urandom_range(32'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_size();
    case ($urandom_range(6))
      0: return 32'h0;
      1: return $urandom_range(256, 1);
      2: return $urandom_range(32'h10_0000, 1);
      3: return 32'hFFFF_FFFF;
      4: return $urandom;
      default: return $urandom_range(32'hFFFF, 1);
    endcase
  endfunction

  function automatic section_request_t directed_entry(int i);
    case (i)
      0: return write_item(4'd0, 32'h1000, 32'h100, 32'h400, 32'h200);
      1: return write_item(4'd1, 32'h1080, 32'h1000, 32'h600, 32'h80);
      2: return write_item(4'd2, 32'h0, 32'h0, 32'h0, 32'h0);
      3: return write_item(4'd3, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      4: return write_item(4'd4, 32'h0, 32'h10, 32'hFFFF_FFF8, 32'h10);
      15: return write_item(4'd15, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1);
      default: return write_item(4'(i), 32'(i) << 24, 32'h80_0000, 32'(i) << 20, 32'h1000);
    endcase
  endfunction

  // mostly lookups aimed at the edges and inside of live sections
  function automatic section_request_t random_request();
    section_request_t r;
    logic [1:0]  k;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    int          pick;
    int          n;
    int          e;
    pick = $urandom_range(99);
    if (pick < 14) begin
      r = write_item(4'($urandom_range(15)), random_base(), random_size(),
                     random_base(), random_size());
      if ($urandom_range(3) == 0) begin
        r.vbase = sb.vbase[$urandom_range(15)];
        r.fbase = sb.fbase[$urandom_range(15)];
      end
    end else if (pick < 18) begin
      r = lookup_item(KIND_UNUSED, $urandom);
    end else if (pick < 80) begin
      k = $urandom_range(1) ? KIND_V2F : KIND_F2V;
      n = sb.active_sections();
      e = (n == 0) ? $urandom_range(15) : $urandom_range(n - 1);
      b = (k == KIND_V2F) ? sb.vbase[e] : sb.fbase[e];
      s = (k == KIND_V2F) ? sb.vsize[e] : sb.fsize[e];
      case ($urandom_range(5))
        0: a = b;
        1: a = b + s - 1;
        2: a = b + s;
        3: a = b - 1;
        default: a = b + ((s == 0) ? 32'h0 : $urandom_range(s - 1));
      endcase
      r = lookup_item(k, a);
    end else begin
      r = lookup_item($urandom_range(1) ? KIND_V2F : KIND_F2V, $urandom);
    end
    return r;
  endfunction

  task automatic send_request(input section_request_t r);
    if (throttle && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    req_valid      <= 1'b1;
    kind           <= r.kind;
    entry_index    <= r.entry;
    virt_base      <= r.vbase;
    virt_size      <= r.vsize;
    file_base      <= r.fbase;
    file_size      <= r.fsize;
    lookup_address <= r.addr;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  task automatic write_section_count(input logic [4:0] v);
    cfg_valid     <= 1'b1;
    section_count <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.count_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // writes give no response, so allow the pipeline to empty after the last one
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (sb.pending_translations.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  initial begin
    section_request_t r;
    logic [4:0] c;
    int sent;
    int settings;
    sb = new();
    throttle = 1'b1;
    settings = 1;
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    section_count  <= '0;
    req_valid      <= 1'b0;
    kind           <= KIND_WRITE;
    entry_index    <= '0;
    virt_base      <= '0;
    virt_size      <= '0;
    file_base      <= '0;
    file_size      <= '0;
    lookup_address <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset, every lookup misses; then all entries are loaded and directed lookups follow
    send_request(lookup_item(KIND_V2F, 32'h0));
    send_request(lookup_item(KIND_F2V, 32'hFFFF_FFFF));
    send_request(lookup_item(KIND_UNUSED, $urandom));
    for (int i = 0; i < SAT_MAX_SECTIONS; i++) send_request(directed_entry(i));
    wait_for_drain();
    write_section_count(5'd16);
    send_request(lookup_item(KIND_V2F, 32'h1000));
    send_request(lookup_item(KIND_V2F, 32'h10FF));
    send_request(lookup_item(KIND_V2F, 32'h1100));
    send_request(lookup_item(KIND_V2F, 32'h0));
    send_request(lookup_item(KIND_V2F, 32'hC));
    send_request(lookup_item(KIND_F2V, 32'hFFFF_FFFF));
    send_request(lookup_item(KIND_V2F, 32'hFFF));
    wait_for_drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: c = 5'd16;
        1: c = 5'd31;
        2: c = 5'd1;
        3: c = 5'd17;
        4: c = 5'd0;
        5: c = 5'd8;
        default: c = 5'($urandom_range(31));
      endcase
      write_section_count(c);
      settings++;
      throttle = (p != 1);
      sent = 0;
      while (sent < ((p == 4) ? 150 : 290)) begin
        r = random_request();
        send_request(r);
        if (r.kind != KIND_UNUSED) sent++;
      end
      wait_for_drain();
    end
    throttle = 1'b1;

    $display("covered %0d lookups (%0d hits, %0d misses) and %0d table writes",
             sb.hits + sb.misses, sb.hits, sb.misses, sb.writes);
    $display("under %0d section count settings in %0d cycles, %0d mismatches",
             settings, cycle_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_translations.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
